### rtl/slsfr_pkg.sv
package slsfr_pkg;

	localparam int BYTE_W   = 8;
	localparam int LEN_W    = 6;
	localparam int POS_W    = 5;
	localparam int CFG_IW   = 2;
	localparam int RUN_MAX  = 32;

	localparam logic [CFG_IW-1:0] CFG_SYNC_FIRST  = 2'd0;
	localparam logic [CFG_IW-1:0] CFG_SYNC_SECOND = 2'd1;
	localparam logic [CFG_IW-1:0] CFG_MAX_LENGTH  = 2'd2;

	localparam logic [BYTE_W-1:0] SYNC_FIRST_RST  = 8'd170;
	localparam logic [BYTE_W-1:0] SYNC_SECOND_RST = 8'd175;
	localparam logic [LEN_W-1:0]  MAX_LENGTH_RST  = 6'd30;

	typedef enum logic [5:0] {
		PH_SYNC1 = 6'b000001,
		PH_SYNC2 = 6'b000010,
		PH_ID    = 6'b000100,
		PH_LEN   = 6'b001000,
		PH_DATA  = 6'b010000,
		PH_SUM   = 6'b100000
	} phase_t;

	typedef enum logic [3:0] {
		SQ_IDLE = 4'b0001,
		SQ_EXEC = 4'b0010,
		SQ_READ = 4'b0100,
		SQ_OUT  = 4'b1000
	} seq_t;

endpackage

### rtl/slsfr_pbuf.sv
module slsfr_pbuf import slsfr_pkg::*; #(
	parameter int DEPTH = 32,
	parameter int AW    = 5
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [AW-1:0]     wr_addr,
	input  logic [BYTE_W-1:0] wr_data,
	input  logic              rd_en,
	input  logic [AW-1:0]     rd_addr,
	output logic [BYTE_W-1:0] rd_data
);

	logic [BYTE_W-1:0] mem_q [DEPTH];
	logic [BYTE_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

### rtl/sync_length_sum_frame_receiver.sv
// Frame receiver for a two-sync-byte, ID, length, payload, checksum byte stream.
//
// Input stream (s_*): one request per received byte; s_tuser = 1 marks a
// no-data/timeout event that sends the parser back to hunting for sync.
// Output stream (m_*): one request per payload byte of a good frame, tlast on
// the final one; a zero-length frame gives a single request without data, a
// checksum error a single request with the error flag set.
// Configuration: cfg_we/cfg_index/cfg_data, write only while idle.
//
// Sequence: each input request is accepted, then makes one pass through
// the shared 8-bit add/compare unit; s_tready is low during that pass and
// while a result run is delivered. The checksum byte of a good frame adds
// a payload buffer read and then an output per payload byte, more if
// m_tready is held low: the output holds until taken and nothing new is
// accepted meanwhile.
// Reset: registers return to their defaults, parser hunts for the first sync
// byte; the payload buffer is not cleared and needs no clearing pass.
module sync_length_sum_frame_receiver import slsfr_pkg::*; #(
	parameter int PAYLOAD_DEPTH = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [7:0]          s_tdata,   // rx_byte
	input  logic                s_tuser,   // op
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [31:0]         m_tdata,   // message_id, payload_length, byte_position,
	                                       // payload_byte, zero fill
	output logic [1:0]          m_tuser,   // status, has_data
	output logic                m_tlast,
	input  logic                cfg_we,
	input  logic [CFG_IW-1:0]   cfg_index,
	input  logic [BYTE_W-1:0]   cfg_data
);

	localparam int AW = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;
	localparam int LIM_I = (PAYLOAD_DEPTH < RUN_MAX) ? PAYLOAD_DEPTH : RUN_MAX;
	localparam logic [LEN_W-1:0] LEN_CAP = LEN_W'(LIM_I);
	localparam logic [LEN_W:0] DEPTH_V = (LEN_W + 1)'(PAYLOAD_DEPTH);

	logic [BYTE_W-1:0] sync_first_q, sync_second_q;
	logic [LEN_W-1:0]  max_length_q;

	seq_t              seq_q;
	phase_t            phase_q;
	logic              op_q;
	logic [BYTE_W-1:0] byte_q;
	logic [BYTE_W-1:0] frame_id_q;
	logic [LEN_W-1:0]  frame_length_q;
	logic [LEN_W-1:0]  fill_q;
	logic [BYTE_W-1:0] sum_q;
	logic [POS_W-1:0]  emit_q;
	logic              status_q, has_q, last_q;
	logic [POS_W-1:0]  pos_q;

	logic [BYTE_W-1:0] alu_a, alu_b, alu_sum;
	logic              alu_eq;
	logic [LEN_W-1:0]  len_lim;
	logic [LEN_W-1:0]  fill_nxt;
	logic              wr_en, rd_en;
	logic [LEN_W-1:0]  emit_ext;
	logic [BYTE_W-1:0] rd_data;

	// shared 8-bit add/compare unit
	always_comb begin
		alu_a = sum_q;
		alu_b = byte_q;
		if (seq_q == SQ_OUT) begin
			alu_a = BYTE_W'(emit_q);
			alu_b = BYTE_W'(1);
		end else if (phase_q == PH_SYNC1) begin
			alu_a = '0;
		end
	end
	assign alu_sum = alu_a + alu_b;
	assign alu_eq  = (alu_a == alu_b);

	assign len_lim  = (max_length_q < LEN_CAP) ? max_length_q : LEN_CAP;
	assign fill_nxt = fill_q + LEN_W'(1);
	assign emit_ext = LEN_W'(emit_q);

	assign wr_en = (seq_q == SQ_EXEC) && !op_q && (phase_q == PH_DATA)
	               && ({1'b0, fill_q} < DEPTH_V);
	assign rd_en = (seq_q == SQ_READ);

	slsfr_pbuf #(
		.DEPTH (PAYLOAD_DEPTH),
		.AW    (AW)
	) u_pbuf (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (fill_q[AW-1:0]),
		.wr_data (byte_q),
		.rd_en   (rd_en),
		.rd_addr (emit_ext[AW-1:0]),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_first_q  <= SYNC_FIRST_RST;
			sync_second_q <= SYNC_SECOND_RST;
			max_length_q  <= MAX_LENGTH_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_SYNC_FIRST:  sync_first_q  <= cfg_data;
				CFG_SYNC_SECOND: sync_second_q <= cfg_data;
				CFG_MAX_LENGTH:  max_length_q  <= cfg_data[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_q   <= s_tuser;
			byte_q <= s_tdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q          <= SQ_IDLE;
			phase_q        <= PH_SYNC1;
			frame_id_q     <= '0;
			frame_length_q <= '0;
			fill_q         <= '0;
			sum_q          <= '0;
			emit_q         <= '0;
			status_q       <= 1'b0;
			has_q          <= 1'b0;
			last_q         <= 1'b0;
			pos_q          <= '0;
		end else begin
			unique case (seq_q)
				SQ_IDLE: begin
					if (s_tvalid) begin
						seq_q <= SQ_EXEC;
					end
				end
				SQ_EXEC: begin
					seq_q <= SQ_IDLE;
					if (op_q) begin
						phase_q <= PH_SYNC1;
					end else begin
						unique case (phase_q)
							PH_SYNC1: begin
								sum_q   <= alu_sum;
								phase_q <= (byte_q == sync_first_q) ? PH_SYNC2 : PH_SYNC1;
							end
							PH_SYNC2: begin
								sum_q   <= alu_sum;
								phase_q <= (byte_q == sync_second_q) ? PH_ID : PH_SYNC1;
							end
							PH_ID: begin
								sum_q      <= alu_sum;
								frame_id_q <= byte_q;
								phase_q    <= PH_LEN;
							end
							PH_LEN: begin
								if (byte_q <= BYTE_W'(len_lim)) begin
									sum_q          <= alu_sum;
									frame_length_q <= byte_q[LEN_W-1:0];
									fill_q         <= '0;
									phase_q        <= (byte_q != '0) ? PH_DATA : PH_SUM;
								end else begin
									phase_q <= PH_SYNC1;
								end
							end
							PH_DATA: begin
								sum_q  <= alu_sum;
								fill_q <= fill_nxt;
								if (fill_nxt >= frame_length_q) begin
									phase_q <= PH_SUM;
								end
							end
							PH_SUM: begin
								phase_q <= PH_SYNC1;
								pos_q   <= '0;
								emit_q  <= '0;
								if (!alu_eq) begin
									status_q <= 1'b1;
									has_q    <= 1'b0;
									last_q   <= 1'b1;
									seq_q    <= SQ_OUT;
								end else if (frame_length_q == '0) begin
									status_q <= 1'b0;
									has_q    <= 1'b0;
									last_q   <= 1'b1;
									seq_q    <= SQ_OUT;
								end else begin
									status_q <= 1'b0;
									has_q    <= 1'b1;
									seq_q    <= SQ_READ;
								end
							end
							default: phase_q <= PH_SYNC1;
						endcase
					end
				end
				SQ_READ: begin
					pos_q  <= emit_q;
					last_q <= (emit_ext + LEN_W'(1) == frame_length_q);
					seq_q  <= SQ_OUT;
				end
				SQ_OUT: begin
					if (m_tready) begin
						if (last_q) begin
							seq_q <= SQ_IDLE;
						end else begin
							emit_q <= alu_sum[POS_W-1:0];
							seq_q  <= SQ_READ;
						end
					end
				end
				default: seq_q <= SQ_IDLE;
			endcase
		end
	end

	assign s_tready = (seq_q == SQ_IDLE);
	assign m_tvalid = (seq_q == SQ_OUT);
	assign m_tlast  = last_q;
	assign m_tuser  = {has_q, status_q};
	assign m_tdata  = {5'b0, (has_q ? rd_data : {BYTE_W{1'b0}}), pos_q, frame_length_q,
	                   frame_id_q};

`ifndef SYNTHESIS
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid))
		else $error("input ready while a result is pending");

	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[0]) |-> (m_tlast && !m_tuser[1]))
		else $error("error result not a single marked result");

	a_nodata_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser[1]) |-> (m_tdata[26:14] == '0))
		else $error("result without data carries position or byte");

	a_run_end: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && m_tlast) |=> s_tready)
		else $error("parser not ready after end of run");
`endif

endmodule
